[sv/fccb_pkg.sv]
`timescale 1ns / 1ps

package fccb_pkg;

   // Field widths on the stream and register ports.
   localparam int FIELD_W    = 32;
   localparam int DIST_W     = 31;
   localparam int NUM_COORDS = 6;
   localparam int REQ_DATA_W = FIELD_W * NUM_COORDS;
   localparam int CLIP_W     = 7 - 1;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_SIDES  = 4;

   // Bit positions inside clip_bits.
   localparam int BIT_NEAR = 4;
   localparam int BIT_FAR  = 5;

   // Register map, one word per register.
   typedef enum logic [2:0] {
      REG_PERSPECTIVE = 3'd0,
      REG_DISTANCE    = 3'd1,
      REG_WIN_LEFT    = 3'd2,
      REG_WIN_RIGHT   = 3'd3,
      REG_WIN_TOP     = 3'd4,
      REG_WIN_BOTTOM  = 3'd5,
      REG_NEAR        = 3'd6,
      REG_FAR         = 3'd7
   } fccb_reg_type;

   // Side plane lanes.
   typedef enum logic [1:0] {
      SIDE_LEFT   = 2'd0,
      SIDE_RIGHT  = 2'd1,
      SIDE_TOP    = 2'd2,
      SIDE_BOTTOM = 2'd3
   } fccb_side_type;

   // Reset values of the registers.
   localparam logic [FIELD_W-1:0] RST_WIN_LEFT   = 32'hFFFF_0000;
   localparam logic [FIELD_W-1:0] RST_WIN_RIGHT  = 32'h0001_0000;
   localparam logic [FIELD_W-1:0] RST_WIN_TOP    = 32'h0001_0000;
   localparam logic [FIELD_W-1:0] RST_WIN_BOTTOM = 32'hFFFF_0000;
   localparam logic [FIELD_W-1:0] RST_NEAR       = 32'd6554;
   localparam logic [FIELD_W-1:0] RST_FAR        = 32'h7FFF_FFFF;
   localparam logic [DIST_W-1:0]  RST_DISTANCE   = 31'd65536;

   // What one lane found for its side plane.
   typedef struct packed {
      logic point_out;  // Point lies strictly outside.
      logic box_out;    // No box corner lies strictly inside.
   } fccb_lane_res_type;

   // Item information carried alongside the lanes.
   typedef struct packed {
      logic box_mode;
      logic near_hit;
      logic far_hit;
   } fccb_tag_type;

endpackage

[sv/fccb_lane.sv]
`timescale 1ns / 1ps

module fccb_lane #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 mul_en,
   input  logic                                 cmp_en,
   input  logic signed [fccb_pkg::FIELD_W-1:0]  scale,
   input  logic signed [COORD_WIDTH-1:0]        edge_pos,
   input  logic                                 flip,
   input  logic signed [COORD_WIDTH-1:0]        coord_lo,
   input  logic signed [COORD_WIDTH-1:0]        coord_hi,
   input  logic signed [COORD_WIDTH-1:0]        depth_lo,
   input  logic signed [COORD_WIDTH-1:0]        depth_hi,
   output fccb_pkg::fccb_lane_res_type          res
);
   import fccb_pkg::*;

   // Products are exact: scale times coordinate, or edge times depth.
   localparam int PW = COORD_WIDTH + ((COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W);

   logic signed [PW-1:0] cprod_in [2];
   logic signed [PW-1:0] dprod_in [2];
   logic signed [PW-1:0] cprod_ff [2];
   logic signed [PW-1:0] dprod_ff [2];
   logic                 pos      [2][2];
   logic                 neg      [2][2];
   fccb_lane_res_type    res_in;
   fccb_lane_res_type    res_ff;

   // Multiplier stage: two coordinate products and two depth products.
   always_comb begin
      cprod_in[0] = PW'(scale) * PW'(coord_lo);
      cprod_in[1] = PW'(scale) * PW'(coord_hi);
      dprod_in[0] = PW'(edge_pos) * PW'(depth_lo);
      dprod_in[1] = PW'(edge_pos) * PW'(depth_hi);
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         cprod_ff <= cprod_in;
         dprod_ff <= dprod_in;
      end
   end

   // Sign stage: the plane value is the product difference, negated when flip is set.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            pos[i][j] = flip ? (cprod_ff[i] < dprod_ff[j]) : (cprod_ff[i] > dprod_ff[j]);
            neg[i][j] = flip ? (cprod_ff[i] > dprod_ff[j]) : (cprod_ff[i] < dprod_ff[j]);
         end
      end
      res_in.point_out = neg[0][0];
      res_in.box_out   = !(pos[0][0] || pos[0][1] || pos[1][0] || pos[1][1]);
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

[sv/fccb_merge.sv]
`timescale 1ns / 1ps

module fccb_merge (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic                                    out_en,
   input  fccb_pkg::fccb_lane_res_type             lane_res [fccb_pkg::NUM_SIDES],
   input  fccb_pkg::fccb_tag_type                  tag,
   output logic                                    rsp_tvalid,
   // rsp_tdata fields from bit 0: clip_bits[5:0], inside_res[6], zero pad[7].
   output logic [fccb_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   import fccb_pkg::*;

   logic [CLIP_W-1:0]     clip_in;
   logic                  inside_in;
   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff;

   // Combine the side lanes with the depth tests of the item.
   always_comb begin
      clip_in = '0;
      for (int k = 0; k < NUM_SIDES; k++) begin
         clip_in[k] = tag.box_mode ? lane_res[k].box_out : lane_res[k].point_out;
      end
      clip_in[BIT_NEAR] = !tag.box_mode && tag.near_hit;
      clip_in[BIT_FAR]  = !tag.box_mode && tag.far_hit;
      inside_in = (clip_in[NUM_SIDES-1:0] == '0);
   end

   // Output register; it loads whenever it is empty or being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_en) begin
         valid_ff <= in_valid;
      end
      if (out_en && in_valid) begin
         data_ff <= RSP_DATA_W'({inside_in, clip_in});
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

[sv/frustum_clip_code_and_box_cull.sv]
`timescale 1ns / 1ps

// Frustum clip codes and box culling.
// The req channel carries one point or one axis-aligned box per transaction:
// tdata holds first_x, first_y, first_z, second_x, second_y, second_z (32 bits
// each, from bit 0 up) and tuser holds mode (0 point, 1 box). The rsp channel
// returns one transaction per request with clip_bits in tdata[5:0] and
// inside_res in tdata[6].
// The frustum is set through the csr port, one register per 32-bit word.
// Registers must be written only while no transaction is in flight; the block
// itself does not enforce this. An accepted item passes an input register,
// the lane multipliers, the lane sign compares, then the merging output
// register. Throughput is one transaction per cycle while req_tready holds;
// four side-plane lanes each form four products at once, so a box costs no
// more than a point. When the receiver stalls, each stage keeps its item and
// the pipeline fills; req_tready drops only once every stage holds an item.
// Reset returns the registers to their defaults and empties the pipeline.
module frustum_clip_code_and_box_cull #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata fields from bit 0: first_x, first_y, first_z, second_x,
   // second_y, second_z, 32 bits each.
   input  logic [fccb_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser fields from bit 0: mode.
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata fields from bit 0: clip_bits[5:0], inside_res[6], zero pad[7].
   output logic [fccb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fccb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fccb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fccb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import fccb_pkg::*;

   localparam int EXT_W = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // Field cut or zero-extended to COORD_WIDTH bits, read as two's complement.
   function automatic coord_type to_coord(input logic [FIELD_W-1:0] v);
      logic [EXT_W-1:0] wide;
      wide = EXT_W'(v);
      return coord_type'(wide[COORD_WIDTH-1:0]);
   endfunction

   // Configuration registers.
   logic                persp_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [FIELD_W-1:0]  win_left_ff;
   logic [FIELD_W-1:0]  win_right_ff;
   logic [FIELD_W-1:0]  win_top_ff;
   logic [FIELD_W-1:0]  win_bottom_ff;
   logic [FIELD_W-1:0]  near_ff;
   logic [FIELD_W-1:0]  far_ff;
   fccb_reg_type        reg_sel;
   logic                csr_write;

   assign reg_sel    = fccb_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         persp_ff      <= 1'b1;
         dist_ff       <= RST_DISTANCE;
         win_left_ff   <= RST_WIN_LEFT;
         win_right_ff  <= RST_WIN_RIGHT;
         win_top_ff    <= RST_WIN_TOP;
         win_bottom_ff <= RST_WIN_BOTTOM;
         near_ff       <= RST_NEAR;
         far_ff        <= RST_FAR;
      end else if (csr_write) begin
         case (reg_sel)
            REG_PERSPECTIVE: persp_ff      <= csr_pwdata[0];
            REG_DISTANCE:    dist_ff       <= csr_pwdata[DIST_W-1:0];
            REG_WIN_LEFT:    win_left_ff   <= csr_pwdata;
            REG_WIN_RIGHT:   win_right_ff  <= csr_pwdata;
            REG_WIN_TOP:     win_top_ff    <= csr_pwdata;
            REG_WIN_BOTTOM:  win_bottom_ff <= csr_pwdata;
            REG_NEAR:        near_ff       <= csr_pwdata;
            REG_FAR:         far_ff        <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (reg_sel)
         REG_PERSPECTIVE: csr_prdata = CSR_DATA_W'(persp_ff);
         REG_DISTANCE:    csr_prdata = CSR_DATA_W'(dist_ff);
         REG_WIN_LEFT:    csr_prdata = win_left_ff;
         REG_WIN_RIGHT:   csr_prdata = win_right_ff;
         REG_WIN_TOP:     csr_prdata = win_top_ff;
         REG_WIN_BOTTOM:  csr_prdata = win_bottom_ff;
         REG_NEAR:        csr_prdata = near_ff;
         REG_FAR:         csr_prdata = far_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // Ordered window edges; change them only while the pipeline is empty.
   coord_type wl_c, wr_c, wt_c, wb_c, near_c, far_c;
   coord_type min_x, max_x, min_y, max_y;

   always_comb begin
      wl_c   = to_coord(win_left_ff);
      wr_c   = to_coord(win_right_ff);
      wt_c   = to_coord(win_top_ff);
      wb_c   = to_coord(win_bottom_ff);
      near_c = to_coord(near_ff);
      far_c  = to_coord(far_ff);
      min_x  = (wl_c < wr_c) ? wl_c : wr_c;
      max_x  = (wl_c < wr_c) ? wr_c : wl_c;
      min_y  = (wt_c < wb_c) ? wt_c : wb_c;
      max_y  = (wt_c < wb_c) ? wb_c : wt_c;
   end

   // Pipeline flow: each stage moves on when the next one is free or moving.
   logic v0_ff, v1_ff, v2_ff;
   logic en0, en1, en2, en3;

   assign en3        = !rsp_tvalid || rsp_tready;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign en0        = !v0_ff || en1;
   assign req_tready = en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= req_tvalid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
      end
   end

   // Input register.
   logic      mode_ff;
   coord_type x_lo_ff, y_lo_ff, z_lo_ff, x_hi_ff, y_hi_ff, z_hi_ff;

   always_ff @(posedge clock) begin
      if (en0 && req_tvalid) begin
         mode_ff <= req_tuser;
         x_lo_ff <= to_coord(req_tdata[0*FIELD_W +: FIELD_W]);
         y_lo_ff <= to_coord(req_tdata[1*FIELD_W +: FIELD_W]);
         z_lo_ff <= to_coord(req_tdata[2*FIELD_W +: FIELD_W]);
         x_hi_ff <= to_coord(req_tdata[3*FIELD_W +: FIELD_W]);
         y_hi_ff <= to_coord(req_tdata[4*FIELD_W +: FIELD_W]);
         z_hi_ff <= to_coord(req_tdata[5*FIELD_W +: FIELD_W]);
      end
   end

   // Item tag follows the lanes: box flag and the depth tests of the point.
   fccb_tag_type tag1_ff, tag2_ff;

   always_ff @(posedge clock) begin
      if (en1 && v0_ff) begin
         tag1_ff.box_mode <= mode_ff;
         tag1_ff.near_hit <= (z_lo_ff < near_c);
         tag1_ff.far_hit  <= (z_lo_ff > far_c);
      end
      if (en2 && v1_ff) begin
         tag2_ff <= tag1_ff;
      end
   end

   // Lane operands. Orthographic mode uses unit scale and unit depth, and
   // swaps the roles of the top and bottom edges.
   logic signed [FIELD_W-1:0] scale;
   coord_type                 depth_lo, depth_hi;
   coord_type                 lane_edge  [NUM_SIDES];
   coord_type                 lane_lo    [NUM_SIDES];
   coord_type                 lane_hi    [NUM_SIDES];
   logic                      lane_flip  [NUM_SIDES];
   fccb_lane_res_type         lane_res   [NUM_SIDES];

   always_comb begin
      scale    = persp_ff ? FIELD_W'({1'b0, dist_ff}) : FIELD_W'(1);
      depth_lo = persp_ff ? z_lo_ff : coord_type'(1);
      depth_hi = persp_ff ? z_hi_ff : coord_type'(1);

      lane_lo[SIDE_LEFT]     = x_lo_ff;
      lane_hi[SIDE_LEFT]     = x_hi_ff;
      lane_edge[SIDE_LEFT]   = min_x;
      lane_flip[SIDE_LEFT]   = 1'b0;

      lane_lo[SIDE_RIGHT]    = x_lo_ff;
      lane_hi[SIDE_RIGHT]    = x_hi_ff;
      lane_edge[SIDE_RIGHT]  = max_x;
      lane_flip[SIDE_RIGHT]  = 1'b1;

      lane_lo[SIDE_TOP]      = y_lo_ff;
      lane_hi[SIDE_TOP]      = y_hi_ff;
      lane_edge[SIDE_TOP]    = persp_ff ? min_y : max_y;
      lane_flip[SIDE_TOP]    = !persp_ff;

      lane_lo[SIDE_BOTTOM]   = y_lo_ff;
      lane_hi[SIDE_BOTTOM]   = y_hi_ff;
      lane_edge[SIDE_BOTTOM] = persp_ff ? max_y : min_y;
      lane_flip[SIDE_BOTTOM] = persp_ff;
   end

   for (genvar k = 0; k < NUM_SIDES; k++) begin : g_lane
      fccb_lane #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_lane (
         .clock    (clock),
         .mul_en   (en1 && v0_ff),
         .cmp_en   (en2 && v1_ff),
         .scale    (scale),
         .edge_pos (lane_edge[k]),
         .flip     (lane_flip[k]),
         .coord_lo (lane_lo[k]),
         .coord_hi (lane_hi[k]),
         .depth_lo (depth_lo),
         .depth_hi (depth_hi),
         .res      (lane_res[k])
      );
   end

   fccb_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v2_ff),
      .out_en     (en3),
      .lane_res   (lane_res),
      .tag        (tag2_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // An accepted transaction always lands in the input register.
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v0_ff)
      else $error("accepted transaction not captured");

   // A blocked sign stage keeps its item.
   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en3) |=> v2_ff)
      else $error("stalled item dropped from sign stage");

   // Backpressure reaches the input only when every stage is occupied.
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v0_ff && v1_ff && v2_ff && rsp_tvalid))
      else $error("input stalled with an empty stage");

endmodule

[dv/frustum_clip_code_and_box_cull_tb.sv]
`timescale 1ns / 1ps

import fccb_pkg::*;

// Tracks the frustum registers, predicts the clip code of every accepted
// request and compares each returned response against the oldest prediction.
class cull_scoreboard;
   typedef struct packed {
      logic       inside_res;
      logic [5:0] clip_bits;
   } clip_code_type;

   logic [FIELD_W-1:0] regs [8];
   clip_code_type      expected_codes [$];
   int                 failures;

   function new();
      regs[REG_PERSPECTIVE] = 32'd1;
      regs[REG_DISTANCE]    = {1'b0, RST_DISTANCE};
      regs[REG_WIN_LEFT]    = RST_WIN_LEFT;
      regs[REG_WIN_RIGHT]   = RST_WIN_RIGHT;
      regs[REG_WIN_TOP]     = RST_WIN_TOP;
      regs[REG_WIN_BOTTOM]  = RST_WIN_BOTTOM;
      regs[REG_NEAR]        = RST_NEAR;
      regs[REG_FAR]         = RST_FAR;
      failures = 0;
   endfunction

   // Mirror a register write; only the implemented bits are kept.
   function void set_reg(fccb_reg_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_PERSPECTIVE: regs[idx] = {31'd0, value[0]};
         REG_DISTANCE:    regs[idx] = {1'b0, value[DIST_W-1:0]};
         default:         regs[idx] = value;
      endcase
   endfunction

   // Exact value of one side plane at (x, y, z); zero or above is inside.
   function logic signed [79:0] side_value(fccb_side_type side,
                                           logic signed [79:0] x,
                                           logic signed [79:0] y,
                                           logic signed [79:0] z);
      logic signed [79:0] wl, wr, wt, wb, lo_x, hi_x, lo_y, hi_y, img_dist;
      wl   = $signed(regs[REG_WIN_LEFT]);
      wr   = $signed(regs[REG_WIN_RIGHT]);
      wt   = $signed(regs[REG_WIN_TOP]);
      wb   = $signed(regs[REG_WIN_BOTTOM]);
      lo_x = (wl < wr) ? wl : wr;
      hi_x = (wl < wr) ? wr : wl;
      lo_y = (wt < wb) ? wt : wb;
      hi_y = (wt < wb) ? wb : wt;
      img_dist = $signed({49'd0, regs[REG_DISTANCE][DIST_W-1:0]});
      if (regs[REG_PERSPECTIVE][0]) begin
         case (side)
            SIDE_LEFT:  return img_dist * x - lo_x * z;
            SIDE_RIGHT: return hi_x * z - img_dist * x;
            SIDE_TOP:   return img_dist * y - lo_y * z;
            default:    return hi_y * z - img_dist * y;
         endcase
      end
      case (side)
         SIDE_LEFT:  return x - lo_x;
         SIDE_RIGHT: return hi_x - x;
         SIDE_TOP:   return hi_y - y;
         default:    return y - lo_y;
      endcase
   endfunction

   // Clip code of a point, or the cull code of the box spanned by two corners.
   function clip_code_type clip_code_of(logic box, logic [REQ_DATA_W-1:0] data);
      logic signed [79:0] corner [2][3];
      logic               any_inside;
      clip_code_type      code;
      code = '0;
      for (int c = 0; c < 2; c++) begin
         for (int a = 0; a < 3; a++) begin
            corner[c][a] = $signed(data[96*c + 32*a +: 32]);
         end
      end
      if (!box) begin
         for (int s = 0; s < NUM_SIDES; s++) begin
            if (side_value(fccb_side_type'(s), corner[0][0], corner[0][1],
                           corner[0][2]) < 0) begin
               code.clip_bits[s] = 1'b1;
            end
         end
         code.clip_bits[BIT_NEAR] = corner[0][2] < $signed(regs[REG_NEAR]);
         code.clip_bits[BIT_FAR]  = corner[0][2] > $signed(regs[REG_FAR]);
      end else begin
         // A side rejects the box when no corner is strictly inside it.
         for (int s = 0; s < NUM_SIDES; s++) begin
            any_inside = 1'b0;
            for (int k = 0; k < 8; k++) begin
               if (side_value(fccb_side_type'(s), corner[(k >> 2) & 1][0],
                              corner[(k >> 1) & 1][1], corner[k & 1][2]) > 0) begin
                  any_inside = 1'b1;
               end
            end
            code.clip_bits[s] = !any_inside;
         end
      end
      code.inside_res = (code.clip_bits[3:0] == 4'd0);
      return code;
   endfunction

   function void note_request(logic box, logic [REQ_DATA_W-1:0] data);
      expected_codes.push_back(clip_code_of(box, data));
   endfunction

   function void check_response(logic [RSP_DATA_W-1:0] data);
      clip_code_type want;
      if (expected_codes.size() == 0) begin
         $error("response transaction with no request pending: %0h", data);
         failures++;
         return;
      end
      want = expected_codes.pop_front();
      if (data[5:0] !== want.clip_bits) begin
         $error("clip_bits expected %0h actual %0h", want.clip_bits, data[5:0]);
         failures++;
      end
      if (data[6] !== want.inside_res) begin
         $error("inside_res expected %0h actual %0h", want.inside_res, data[6]);
         failures++;
      end
   endfunction

   function int outstanding();
      return expected_codes.size();
   endfunction
endclass

module frustum_clip_code_and_box_cull_tb;

   localparam logic [31:0] ONE       = 32'h0001_0000;
   localparam logic [31:0] MINV      = 32'h8000_0000;
   localparam logic [31:0] MAXV      = 32'h7FFF_FFFF;
   localparam int          HOLD_OFF  = 300;
   localparam int          STUCK_MAX = 5000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cull_scoreboard sb = new();
   logic           no_idle = 1'b0;
   logic           hold_off_req = 1'b0;
   int             stuck_cycles = 0;

   frustum_clip_code_and_box_cull DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both channels are observed with the values seen at the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      end
   end

   // The run is stopped when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_MAX) begin
         $display("frustum_clip_code_and_box_cull: mismatch");
         $finish;
      end
   end

   // The receiver stalls at random, and for a long stretch on request.
   initial begin : receiver
      int held;
      held = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            held = HOLD_OFF;
         end
         if (held > 0) begin
            held--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(0, 99) >= 20);
         end
      end
   end

   function automatic logic [31:0] spread(int unsigned span);
      return int'($urandom_range(0, 2 * span)) - int'(span);
   endfunction

   // A value at, next to, or somewhat around an anchor, now and then anywhere.
   function automatic logic [31:0] jitter(logic [31:0] anchor);
      case ($urandom_range(0, 5))
         0, 1:    return anchor;
         2:       return anchor + $urandom_range(0, 2) - 1;
         3:       return anchor + spread(1 << 12);
         4:       return spread(1 << 18);
         default: return $urandom;
      endcase
   endfunction

   // Offers one transaction and returns at the edge where it is accepted.
   task automatic send_item(input logic box, input logic [31:0] x0, input logic [31:0] y0,
                            input logic [31:0] z0, input logic [31:0] x1,
                            input logic [31:0] y1, input logic [31:0] z1);
      while (!no_idle && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= box;
      req_tdata  <= {z1, y1, x1, z0, y0, x0};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Half of the items sit on or near the window planes and depth limits.
   task automatic send_random_item();
      logic [31:0] f [6];
      logic        box;
      int          kind;
      box  = $urandom_range(0, 1);
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         foreach (f[i]) f[i] = $urandom;
      end else if (kind < 7) begin
         case ($urandom_range(0, 3))
            0:       f[2] = sb.regs[REG_DISTANCE];
            1:       f[2] = jitter(sb.regs[REG_NEAR]);
            2:       f[2] = jitter(sb.regs[REG_FAR]);
            default: f[2] = spread(1 << 18);
         endcase
         f[0] = jitter($urandom_range(0, 1) ? sb.regs[REG_WIN_LEFT] : sb.regs[REG_WIN_RIGHT]);
         f[1] = jitter($urandom_range(0, 1) ? sb.regs[REG_WIN_TOP] : sb.regs[REG_WIN_BOTTOM]);
         f[3] = jitter(f[0]);
         f[4] = jitter(f[1]);
         f[5] = jitter(f[2]);
      end else begin
         foreach (f[i]) f[i] = spread(1 << 18);
      end
      send_item(box, f[0], f[1], f[2], f[3], f[4], f[5]);
   endtask

   // Stops offering and waits until every response has come back. The first
   // edge lets the monitor record the transaction accepted at the last edge.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // One register write: a setup phase, then an access phase.
   task automatic write_reg(input fccb_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   // Each phase rewrites every register; some phases use the extreme values.
   task automatic program_frustum(input int phase);
      logic [31:0] v [8];
      logic        persp;
      persp               = !(phase == 1 || phase == 4 || phase == 7);
      v[REG_PERSPECTIVE]  = ($urandom & 32'hFFFF_FFFE) | {31'd0, persp};
      v[REG_DISTANCE]     = {$urandom_range(0, 1) == 1, 31'($urandom_range(1 << 12, 1 << 18))};
      v[REG_WIN_LEFT]     = spread(1 << 18);
      v[REG_WIN_RIGHT]    = spread(1 << 18);
      v[REG_WIN_TOP]      = spread(1 << 18);
      v[REG_WIN_BOTTOM]   = spread(1 << 18);
      v[REG_NEAR]         = spread(1 << 17);
      v[REG_FAR]          = spread(1 << 20);
      case (phase)
         2: begin
            v[REG_DISTANCE]   = 32'hFFFF_FFFF;
            v[REG_WIN_LEFT]   = MAXV;
            v[REG_WIN_RIGHT]  = MINV;
            v[REG_WIN_TOP]    = MINV;
            v[REG_WIN_BOTTOM] = MAXV;
            v[REG_NEAR]       = MINV;
            v[REG_FAR]        = MAXV;
         end
         3: begin
            v[REG_DISTANCE] = MINV;
            v[REG_NEAR]     = MAXV;
            v[REG_FAR]      = MINV;
         end
         4: begin
            v[REG_WIN_LEFT]   = MAXV;
            v[REG_WIN_RIGHT]  = MINV;
            v[REG_WIN_TOP]    = MAXV;
            v[REG_WIN_BOTTOM] = MINV;
            v[REG_NEAR]       = MAXV;
            v[REG_FAR]        = MINV;
         end
         default: ;
      endcase
      for (int r = 0; r < 8; r++) write_reg(fccb_reg_type'(r), v[r]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stimulus
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points under the reset frustum: planes, depth limits, extremes.
      send_item(1'b0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, -ONE, 32'd0, ONE, MAXV, MINV, MAXV);
      send_item(1'b0, -ONE - 1, 32'd0, ONE, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, ONE + 1, 32'd0, ONE, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, 32'd0, -ONE - 1, ONE, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, 32'd0, ONE + 1, ONE, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, ONE, ONE, ONE, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, 32'd0, 32'd0, 32'd6553, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, 32'd0, 32'd0, 32'd6554, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, 32'd0, 32'd0, -ONE, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, MINV, MINV, MINV, MAXV, MAXV, MAXV);
      send_item(1'b0, MAXV, MAXV, MAXV, MINV, MINV, MINV);
      send_item(1'b0, '1, '1, '1, '1, '1, '1);

      // Directed boxes: inside, outside, touching, unordered, degenerate.
      send_item(1'b1, -ONE, -ONE, ONE, ONE, ONE, 2 * ONE);
      send_item(1'b1, -10 * ONE, 32'd0, ONE, -5 * ONE, 32'd0, 2 * ONE);
      send_item(1'b1, -3 * ONE, 32'd0, ONE, -ONE, 32'd0, ONE);
      send_item(1'b1, ONE, ONE, 2 * ONE, -ONE, -ONE, ONE);
      send_item(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_item(1'b1, MINV, MINV, MINV, MAXV, MAXV, MAXV);
      send_item(1'b1, MAXV, MAXV, MAXV, MINV, MINV, MINV);
      send_item(1'b1, 32'd0, 32'd0, -ONE, 32'd0, 32'd0, 2 * ONE);
      send_item(1'b1, 5 * ONE, 5 * ONE, ONE, 6 * ONE, 6 * ONE, ONE);
      send_item(1'b1, '1, '1, '1, '1, '1, '1);

      repeat (130) send_random_item();

      // Random phases, each under its own frustum.
      for (int phase = 1; phase <= 7; phase++) begin
         wait_drained();
         program_frustum(phase);
         no_idle = (phase == 4);
         for (int n = 0; n < 140; n++) begin
            // Long receiver stall while requests keep coming.
            if (phase == 3 && n == 40) hold_off_req = 1'b1;
            // Sender pause until the pipeline has emptied.
            if (phase == 5 && n == 70) wait_drained();
            send_random_item();
         end
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("frustum_clip_code_and_box_cull: match");
      end else begin
         $display("frustum_clip_code_and_box_cull: mismatch");
      end
      $finish;
   end

endmodule
